// File: hw/rtl/hee_pkg.sv
// Shared types, character constants and decode helpers for the HTML entity escaper.
package hee_pkg;

  localparam int unsigned UnitW  = 16;
  localparam int unsigned CharW  = 7;
  localparam int unsigned PosW   = 3;
  localparam int unsigned ThrW   = 17;

  typedef logic [UnitW-1:0] unit_t;
  typedef logic [CharW-1:0] char_t;
  typedef logic [PosW-1:0]  pos_t;
  typedef logic [ThrW-1:0]  thr_t;

  typedef enum logic [2:0] {
    KIND_PLAIN,
    KIND_LT,
    KIND_GT,
    KIND_AMP,
    KIND_QUOT,
    KIND_APOS,
    KIND_NUM
  } kind_e;

  localparam char_t CH_AMP  = 7'h26;
  localparam char_t CH_HASH = 7'h23;
  localparam char_t CH_SEMI = 7'h3B;
  localparam char_t CH_ZERO = 7'h30;
  localparam char_t CH_LT   = 7'h3C;
  localparam char_t CH_GT   = 7'h3E;
  localparam char_t CH_QUOT = 7'h22;
  localparam char_t CH_APOS = 7'h27;
  localparam char_t CH_L    = 7'h6C;
  localparam char_t CH_T    = 7'h74;
  localparam char_t CH_G    = 7'h67;
  localparam char_t CH_A    = 7'h61;
  localparam char_t CH_M    = 7'h6D;
  localparam char_t CH_P    = 7'h70;
  localparam char_t CH_Q    = 7'h71;
  localparam char_t CH_U    = 7'h75;
  localparam char_t CH_O    = 7'h6F;
  localparam char_t CH_S    = 7'h73;

  localparam unit_t NumThreshold = 16'd128;

  // One character of the escaped run, handed to the output register.
  typedef struct packed {
    char_t ch;
    logic  last;
    unit_t rem_next;
  } gen_t;

  function automatic kind_e classify(unit_t u);
    kind_e k;
    k = KIND_PLAIN;
    if (u == {9'd0, CH_LT}) begin
      k = KIND_LT;
    end else if (u == {9'd0, CH_GT}) begin
      k = KIND_GT;
    end else if (u == {9'd0, CH_AMP}) begin
      k = KIND_AMP;
    end else if (u == {9'd0, CH_QUOT}) begin
      k = KIND_QUOT;
    end else if (u == {9'd0, CH_APOS}) begin
      k = KIND_APOS;
    end else if (u >= NumThreshold) begin
      k = KIND_NUM;
    end
    return k;
  endfunction

  // Position of the closing ';' in a named entity.
  function automatic pos_t entity_last(kind_e k);
    pos_t p;
    case (k)
      KIND_LT:   p = 3'd3;
      KIND_GT:   p = 3'd3;
      KIND_AMP:  p = 3'd4;
      KIND_QUOT: p = 3'd5;
      KIND_APOS: p = 3'd5;
      default:   p = 3'd0;
    endcase
    return p;
  endfunction

  function automatic char_t entity_char(kind_e k, pos_t p);
    char_t c;
    c = CH_SEMI;
    if (p == 3'd0) begin
      c = CH_AMP;
    end else begin
      case (k)
        KIND_LT: begin
          case (p)
            3'd1:    c = CH_L;
            3'd2:    c = CH_T;
            default: c = CH_SEMI;
          endcase
        end
        KIND_GT: begin
          case (p)
            3'd1:    c = CH_G;
            3'd2:    c = CH_T;
            default: c = CH_SEMI;
          endcase
        end
        KIND_AMP: begin
          case (p)
            3'd1:    c = CH_A;
            3'd2:    c = CH_M;
            3'd3:    c = CH_P;
            default: c = CH_SEMI;
          endcase
        end
        KIND_QUOT: begin
          case (p)
            3'd1:    c = CH_Q;
            3'd2:    c = CH_U;
            3'd3:    c = CH_O;
            3'd4:    c = CH_T;
            default: c = CH_SEMI;
          endcase
        end
        KIND_APOS: begin
          case (p)
            3'd1:    c = CH_A;
            3'd2:    c = CH_P;
            3'd3:    c = CH_O;
            3'd4:    c = CH_S;
            default: c = CH_SEMI;
          endcase
        end
        default: c = CH_SEMI;
      endcase
    end
    return c;
  endfunction

  // d times ten to the power k, for the digit compare ladder.
  function automatic thr_t digit_thr(logic [2:0] k, logic [3:0] d);
    thr_t pw;
    case (k)
      3'd0:    pw = 17'd1;
      3'd1:    pw = 17'd10;
      3'd2:    pw = 17'd100;
      3'd3:    pw = 17'd1000;
      3'd4:    pw = 17'd10000;
      default: pw = 17'd0;
    endcase
    return thr_t'(pw * {13'd0, d});
  endfunction

endpackage

// File: hw/rtl/hee_char_gen.sv
// Character generator: picks one character of the escaped run and the next remainder.
module hee_char_gen
  import hee_pkg::*;
(
  input  unit_t unit_i,
  input  pos_t  pos_i,
  input  unit_t rem_i,
  output gen_t  gen_o
);

  kind_e      kind;
  logic [2:0] num_digits;
  logic [2:0] pow_idx;
  logic [3:0] digit;
  thr_t       sub;
  thr_t       thr;

  always_comb begin
    kind = classify(unit_i);

    // Units that reach the numeric path are at least 128, so three digits minimum.
    if (unit_i >= 16'd10000) begin
      num_digits = 3'd5;
    end else if (unit_i >= 16'd1000) begin
      num_digits = 3'd4;
    end else begin
      num_digits = 3'd3;
    end

    pow_idx = 3'(num_digits + 3'd1 - pos_i);

    // Remainder stays below ten times the current power: one compare per digit value.
    digit = 4'd0;
    sub   = '0;
    for (int d = 1; d <= 9; d++) begin
      thr = digit_thr(pow_idx, 4'(d));
      if ({1'b0, rem_i} >= thr) begin
        digit = 4'(d);
        sub   = thr;
      end
    end

    gen_o.rem_next = rem_i;
    gen_o.last     = 1'b0;
    gen_o.ch       = unit_i[CharW-1:0];

    case (kind)
      KIND_PLAIN: begin
        gen_o.ch   = unit_i[CharW-1:0];
        gen_o.last = 1'b1;
      end
      KIND_NUM: begin
        if (pos_i == 3'd0) begin
          gen_o.ch = CH_AMP;
        end else if (pos_i == 3'd1) begin
          gen_o.ch = CH_HASH;
        end else if (pos_i == 3'(num_digits + 3'd2)) begin
          gen_o.ch   = CH_SEMI;
          gen_o.last = 1'b1;
        end else begin
          gen_o.ch       = CH_ZERO + {3'd0, digit};
          gen_o.rem_next = rem_i - sub[UnitW-1:0];
        end
      end
      default: begin
        gen_o.ch   = entity_char(kind, pos_i);
        gen_o.last = (pos_i == entity_last(kind));
      end
    endcase
  end

endmodule

// File: hw/rtl/html_entity_escaper_unit.sv
// HTML entity escaper top level: input register, character generator, output register.
// An accepted code unit is held in the input register; each of its characters passes through the output register.
// Throughput: one character per cycle, set by the single output register that moves one character
// a beat, while the output is not stalled; an item has 1 character for a plain unit, 4 to 6 for
// a named entity and 6 to 8 for a numeric one.
// Reset clears both valid flags and the run position; payload registers are not reset.
module html_entity_escaper_unit
  import hee_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  unit_t code_unit_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output char_t out_char_o,
  output logic  last_of_run_o
);

  logic  in_valid_q;
  unit_t unit_q;
  unit_t rem_q;
  pos_t  pos_q;

  logic  out_valid_q;
  char_t out_char_q;
  logic  last_q;

  gen_t  gen;
  logic  out_free;
  logic  emit;
  logic  done;
  logic  accept;

  hee_char_gen u_char_gen (
    .unit_i (unit_q),
    .pos_i  (pos_q),
    .rem_i  (rem_q),
    .gen_o  (gen)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = in_valid_q && out_free;
  assign done       = emit && gen.last;
  assign in_stall_o = in_valid_q && !done;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
        pos_q      <= '0;
      end else if (done) begin
        in_valid_q <= 1'b0;
      end else if (emit) begin
        pos_q <= pos_q + 3'd1;
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      unit_q <= code_unit_i;
      rem_q  <= code_unit_i;
    end else if (emit) begin
      rem_q <= gen.rem_next;
    end

    if (emit) begin
      out_char_q <= gen.ch;
      last_q     <= gen.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign last_of_run_o = last_q;

endmodule

// File: test/html_entity_escaper_unit_test.sv
// Self-checking testbench for html_entity_escaper_unit: random stalls, gaps and a long output hold.
module html_entity_escaper_unit_test;
  import hee_pkg::*;

  typedef struct packed {
    char_t ch;
    logic  last;
  } escaped_char_t;

  // Expands each accepted code unit into its escaped run and checks output beats in order.
  class escape_scoreboard;
    escaped_char_t pending_chars[$];
    int            errors;
    int            units_seen;
    int            named_seen;
    int            numeric_seen;
    int            chars_checked;

    function new();
      errors        = 0;
      units_seen    = 0;
      named_seen    = 0;
      numeric_seen  = 0;
      chars_checked = 0;
    endfunction

    function void note_unit(unit_t u);
      char_t run[$];
      int    digits[$];
      int    v;
      escaped_char_t beat;
      units_seen++;
      if (u == {9'd0, CH_LT}) begin
        run.push_back(CH_AMP); run.push_back(CH_L); run.push_back(CH_T);
        run.push_back(CH_SEMI);
        named_seen++;
      end else if (u == {9'd0, CH_GT}) begin
        run.push_back(CH_AMP); run.push_back(CH_G); run.push_back(CH_T);
        run.push_back(CH_SEMI);
        named_seen++;
      end else if (u == {9'd0, CH_AMP}) begin
        run.push_back(CH_AMP); run.push_back(CH_A); run.push_back(CH_M);
        run.push_back(CH_P); run.push_back(CH_SEMI);
        named_seen++;
      end else if (u == {9'd0, CH_QUOT}) begin
        run.push_back(CH_AMP); run.push_back(CH_Q); run.push_back(CH_U);
        run.push_back(CH_O); run.push_back(CH_T); run.push_back(CH_SEMI);
        named_seen++;
      end else if (u == {9'd0, CH_APOS}) begin
        run.push_back(CH_AMP); run.push_back(CH_A); run.push_back(CH_P);
        run.push_back(CH_O); run.push_back(CH_S); run.push_back(CH_SEMI);
        named_seen++;
      end else if (u >= NumThreshold) begin
        // decimal digits, most significant first, no leading zeros
        v = int'(u);
        while (v != 0) begin
          digits.push_front(v % 10);
          v = v / 10;
        end
        run.push_back(CH_AMP);
        run.push_back(CH_HASH);
        foreach (digits[i]) run.push_back(CH_ZERO + char_t'(digits[i]));
        run.push_back(CH_SEMI);
        numeric_seen++;
      end else begin
        run.push_back(u[CharW-1:0]);
      end
      foreach (run[i]) begin
        beat.ch   = run[i];
        beat.last = (i == run.size() - 1);
        pending_chars.push_back(beat);
      end
    endfunction

    function void check_char(char_t ch, logic last);
      escaped_char_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected output beat: out_char %h last_of_run %b", ch, last);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      chars_checked++;
      if (ch !== want.ch) begin
        $error("out_char: expected %h, actual %h", want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %b, actual %b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_stall_o;
  unit_t code_unit_i;
  logic  out_valid_o;
  logic  out_stall_i;
  char_t out_char_o;
  logic  last_of_run_o;

  escape_scoreboard sb;

  html_entity_escaper_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .code_unit_i   (code_unit_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // Offer one code unit after a gap and hold it until the block takes the beat.
  task automatic send_unit(input unit_t u, input int gap);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    code_unit_i = u;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_unit(u);
    @(negedge clk_i);
  endtask

  function automatic unit_t random_unit();
    unit_t u;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       u = {9'd0, CH_LT};
          1:       u = {9'd0, CH_GT};
          2:       u = {9'd0, CH_AMP};
          3:       u = {9'd0, CH_QUOT};
          default: u = {9'd0, CH_APOS};
        endcase
      end
      1, 2:    u = unit_t'($urandom_range(0, 127));
      3:       u = unit_t'($urandom_range(128, 999));
      4:       u = unit_t'($urandom_range(1000, 9999));
      5, 6:    u = unit_t'($urandom_range(10000, 65535));
      7:       u = unit_t'($urandom_range(55296, 57343));
      default: u = unit_t'($urandom);
    endcase
    return u;
  endfunction

  // Receiver: random holds per beat, bursts with none, and one long hold to back up the input.
  initial begin
    int hold;
    int beat_count;
    bit long_hold_done;
    beat_count     = 0;
    long_hold_done = 1'b0;
    out_stall_i    = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!long_hold_done && beat_count == 150) begin
        hold           = 80;
        long_hold_done = 1'b1;
      end else if (beat_count % 64 < 16) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 7);
      end
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_char(out_char_o, last_of_run_o);
      beat_count++;
      @(negedge clk_i);
    end
  end

  initial begin
    unit_t directed[$];
    int    gap;
    int    waited;
    int    leftover;
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    code_unit_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // field extremes, the five named entities, control characters, digit-count edges
    directed.push_back(16'd0);
    directed.push_back(16'd65535);
    directed.push_back(16'd127);
    directed.push_back(16'd128);
    directed.push_back({9'd0, CH_LT});
    directed.push_back({9'd0, CH_GT});
    directed.push_back({9'd0, CH_AMP});
    directed.push_back({9'd0, CH_QUOT});
    directed.push_back({9'd0, CH_APOS});
    directed.push_back(16'd9);
    directed.push_back(16'd10);
    directed.push_back(16'd31);
    directed.push_back(16'h41);
    directed.push_back(16'h3B);
    directed.push_back(16'h23);
    directed.push_back(16'd999);
    directed.push_back(16'd1000);
    directed.push_back(16'd9999);
    directed.push_back(16'd10000);
    directed.push_back(16'hD800);
    directed.push_back(16'hDFFF);
    directed.push_back(16'hD83D);
    directed.push_back(16'hDE00);
    directed.push_back(16'hAAAA);
    directed.push_back(16'h5555);
    foreach (directed[i]) send_unit(directed[i], (i < 10) ? 0 : $urandom_range(0, 7));

    for (int n = 0; n < 380; n++) begin
      gap = (n % 50 < 12) ? 0 : $urandom_range(0, 7);
      send_unit(random_unit(), gap);
    end
    in_valid_i = 1'b0;

    waited = 0;
    while (sb.pending_chars.size() != 0 && waited < 5000) begin
      @(negedge clk_i);
      waited++;
    end
    // room for a stray beat after the last run
    repeat (20) @(negedge clk_i);

    leftover = sb.pending_chars.size();
    if (leftover != 0) $error("%0d expected characters never arrived", leftover);

    $display("Escaped %0d code units (%0d named entities, %0d numeric references).",
             sb.units_seen, sb.named_seen, sb.numeric_seen);
    $display("Checked %0d output characters under random stalls and one long output hold.",
             sb.chars_checked);
    if (sb.errors == 0 && leftover == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
